[design/bci_pkg.sv]
// Shared constants, types and saturation helpers for the barycentric interpolator.
`default_nettype none
package bci_pkg;

  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int WEIGHT_BITS      = 18;
  localparam int SCREEN_BITS      = 32;
  localparam int LOC_BITS         = 16;
  localparam int NV               = 3;

  localparam int DIFF_BITS = LOC_BITS + 1;
  localparam int MAG_BITS  = 2 * DIFF_BITS;
  localparam int PROD_BITS = SCREEN_BITS + WEIGHT_BITS;
  localparam int ACC_BITS  = PROD_BITS + 2;

  // Quotient bits for an area ratio; anything larger saturates.
  localparam int QB_AREA = WEIGHT_BITS - 1;
  // Edge quotient cap: its root must push both edge weights into saturation.
  localparam int FMAX      = ((WEIGHT_FRAC_BITS > WEIGHT_BITS - 1) ?
                              WEIGHT_FRAC_BITS : WEIGHT_BITS - 1) + 1;
  localparam int QB_EDGE   = 2 * FMAX;
  localparam int QUOT_BITS = QB_EDGE + 1;
  localparam int ROOT_BITS = FMAX + 1;
  localparam int CMP_BITS  = MAG_BITS + QB_EDGE + 2 * WEIGHT_FRAC_BITS;
  localparam int STEP_BITS = $clog2(QB_EDGE + 1);

  localparam int S_TDATA_BITS = 128;
  localparam int M_TDATA_BITS = 120;
  localparam int M_PAD_BITS   = M_TDATA_BITS - (3 * WEIGHT_BITS + 2 * SCREEN_BITS);

  localparam logic [2:0] PH_EDGE_T = 3'd0;
  localparam logic [2:0] PH_EDGE_N = 3'd1;
  localparam logic [2:0] PH_TRI_T  = 3'd2;
  localparam logic [2:0] PH_A0     = 3'd3;
  localparam logic [2:0] PH_A1     = 3'd4;
  localparam logic [2:0] PH_A2     = 3'd5;
  localparam logic [2:0] PH_IX     = 3'd6;
  localparam logic [2:0] PH_IY     = 3'd7;

  typedef logic [2:0] phase_t;

  typedef struct packed {
    logic                start;
    logic                edge_mode;
    logic [MAG_BITS-1:0] num;
    logic [MAG_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic                 sat;
    logic [QUOT_BITS-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic                 start;
    logic [QUOT_BITS-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic                 done;
    logic [ROOT_BITS-1:0] root;
  } sqrt_rsp_t;

  function automatic logic signed [WEIGHT_BITS-1:0] sat_weight(input logic signed [31:0] v);
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    hi = 32'sd1 <<< (WEIGHT_BITS - 1);
    hi = hi - 32'sd1;
    lo = -hi - 32'sd1;
    if (v > hi) return WEIGHT_BITS'(hi);
    else if (v < lo) return WEIGHT_BITS'(lo);
    else return WEIGHT_BITS'(v);
  endfunction

  // Floor shift by the weight fraction, then clamp to the screen range.
  function automatic logic signed [SCREEN_BITS-1:0] sat_screen(
      input logic signed [ACC_BITS-1:0] a);
    logic signed [ACC_BITS-1:0] sh;
    logic signed [ACC_BITS-1:0] hi;
    logic signed [ACC_BITS-1:0] lo;
    sh = a >>> WEIGHT_FRAC_BITS;
    hi = (ACC_BITS'(1) <<< (SCREEN_BITS - 1)) - ACC_BITS'(1);
    lo = -hi - ACC_BITS'(1);
    if (sh > hi) return SCREEN_BITS'(hi);
    else if (sh < lo) return SCREEN_BITS'(lo);
    else return SCREEN_BITS'(sh);
  endfunction

endpackage
`default_nettype wire

[design/bci_div.sv]
// Bit-serial restoring divider with an up-front saturation check.
`default_nettype none
module bci_div import bci_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  busy;
  logic                  done_r;
  logic                  sat_r;
  logic [STEP_BITS-1:0]  steps;
  logic [MAG_BITS:0]     rem;
  logic [QB_EDGE-1:0]    low;
  logic [QUOT_BITS-1:0]  quot;
  logic [MAG_BITS-1:0]   den;

  logic [CMP_BITS-1:0]   ext_e, ext_a, lim_e, lim_a;
  logic                  over;
  logic [MAG_BITS:0]     rem0;
  logic [QB_EDGE-1:0]    low0;
  logic [MAG_BITS:0]     trial;
  logic                  ge;

  always_comb begin
    ext_e = CMP_BITS'(req.num) << (2 * WEIGHT_FRAC_BITS);
    ext_a = CMP_BITS'(req.num) << WEIGHT_FRAC_BITS;
    lim_e = CMP_BITS'(req.den) << QB_EDGE;
    lim_a = CMP_BITS'(req.den) << QB_AREA;
    over  = req.edge_mode ? (ext_e >= lim_e) : (ext_a >= lim_a);
    rem0  = req.edge_mode ? (MAG_BITS + 1)'(ext_e >> QB_EDGE)
                          : (MAG_BITS + 1)'(ext_a >> QB_AREA);
    low0  = req.edge_mode ? QB_EDGE'(ext_e) : QB_EDGE'(ext_a << (QB_EDGE - QB_AREA));
    trial = {rem[MAG_BITS-1:0], low[QB_EDGE-1]};
    ge    = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        den   <= req.den;
        sat_r <= over;
        if (over) begin
          quot   <= QUOT_BITS'(1) << QB_EDGE;
          done_r <= 1'b1;
        end else begin
          rem   <= rem0;
          low   <= low0;
          quot  <= '0;
          steps <= req.edge_mode ? STEP_BITS'(QB_EDGE) : STEP_BITS'(QB_AREA);
          busy  <= 1'b1;
        end
      end else if (busy) begin
        rem   <= ge ? (trial - {1'b0, den}) : trial;
        quot  <= {quot[QUOT_BITS-2:0], ge};
        low   <= low << 1;
        steps <= steps - STEP_BITS'(1);
        if (steps == STEP_BITS'(1)) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done_r, sat: sat_r, quot: quot};

endmodule
`default_nettype wire

[design/bci_sqrt.sv]
// Bit-serial integer square root, two radicand bits per step.
`default_nettype none
module bci_sqrt import bci_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  sqrt_req_t req,
  output sqrt_rsp_t rsp
);

  logic                 busy;
  logic                 done_r;
  logic [QUOT_BITS-1:0] xr;
  logic [QUOT_BITS:0]   r;
  logic [QUOT_BITS-1:0] bitm;
  logic [QUOT_BITS:0]   sum;
  logic                 ge;

  always_comb begin
    sum = r + (QUOT_BITS + 1)'(bitm);
    ge  = {1'b0, xr} >= sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        xr   <= req.radicand;
        r    <= '0;
        bitm <= QUOT_BITS'(1) << QB_EDGE;
        busy <= 1'b1;
      end else if (busy) begin
        if (ge) begin
          xr <= xr - QUOT_BITS'(sum);
          r  <= (r >> 1) + (QUOT_BITS + 1)'(bitm);
        end else begin
          r  <= r >> 1;
        end
        bitm <= bitm >> 2;
        if (bitm[0]) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done_r, root: ROOT_BITS'(r)};

endmodule
`default_nettype wire

[design/barycentric_interpolator_top.sv]
// Top level: vertex store, multiply-accumulate sequencer and result register.
//
// Input stream: one vertex per transfer. tdata carries loc_x, loc_y, screen_x,
// screen_y, query_x, query_y; tuser is the usable flag; tlast ends the
// neighborhood and its query point is taken from that same transfer.
// Output stream: one result per neighborhood, tuser is ok, tdata carries the
// three weights and the two interpolated screen values.
// A vertex without tlast leaves the sequencer idle, ready for the next. After the tlast transfer the
// sequencer runs one shared 32x18 multiplier (a multiply state and an
// accumulate state per product), a bit-serial divider and a bit-serial
// square root. Two vertices need a 36-step divide and a 19-step root;
// three vertices need three 17-step divides. A divide that saturates
// skips its steps.
// No new vertex is taken until the result is in the output register; a vertex may
// be taken while an earlier result still waits there. If the receiver stalls,
// the result holds and the sequencer waits before loading the next one.
// Reset empties the neighborhood and drops any pending result.
`default_nettype none
module barycentric_interpolator_top import bci_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // loc_x, loc_y, screen_x, screen_y, query_x, query_y
  input  logic [S_TDATA_BITS-1:0] s_tdata,
  input  logic                    s_tlast,
  // usable
  input  logic                    s_tuser,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // weight_0, weight_1, weight_2, interp_x, interp_y, zero pad
  output logic [M_TDATA_BITS-1:0] m_tdata,
  // ok
  output logic                    m_tuser
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_END  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_SQRT = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0] state;
  phase_t     phase;
  logic [1:0] op;

  logic signed [LOC_BITS-1:0]    vx [NV];
  logic signed [LOC_BITS-1:0]    vy [NV];
  logic signed [SCREEN_BITS-1:0] sx [NV];
  logic signed [SCREEN_BITS-1:0] sy [NV];
  logic signed [LOC_BITS-1:0]    qx, qy;
  logic [2:0]                    vcount;
  logic                          bad;
  logic [1:0]                    fcnt;

  logic signed [PROD_BITS-1:0]   prod;
  logic signed [ACC_BITS-1:0]    acc;
  logic [MAG_BITS-1:0]           tval;
  logic [MAG_BITS-1:0]           tot_mag;
  logic                          tot_neg;
  logic                          div_neg;
  logic signed [WEIGHT_BITS-1:0] w [NV];
  logic signed [SCREEN_BITS-1:0] ix, iy;
  logic                          ok_r;

  div_req_t  div_req;
  div_rsp_t  div_rsp;
  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;

  // Input unpack
  logic signed [LOC_BITS-1:0]    in_loc_x, in_loc_y, in_qx, in_qy;
  logic signed [SCREEN_BITS-1:0] in_sx, in_sy;
  logic [2:0]                    cnt_new;
  logic                          bad_new;

  assign in_loc_x = s_tdata[15:0];
  assign in_loc_y = s_tdata[31:16];
  assign in_sx    = s_tdata[63:32];
  assign in_sy    = s_tdata[95:64];
  assign in_qx    = s_tdata[111:96];
  assign in_qy    = s_tdata[127:112];
  assign cnt_new  = (vcount < 3'd4) ? vcount + 3'd1 : vcount;
  assign bad_new  = bad | ~s_tuser;
  assign s_tready = (state == ST_IDLE);

  // Operand selection
  logic signed [LOC_BITS-1:0]    px [4];
  logic signed [LOC_BITS-1:0]    py [4];
  logic [1:0]                    a_i, b_i, c_i;
  logic                          sq;
  logic                          geo;
  logic signed [DIFF_BITS-1:0]   dbx, dby, dcx, dcy, f1, f2;
  logic signed [SCREEN_BITS-1:0] ma;
  logic signed [WEIGHT_BITS-1:0] mb;
  logic                          subtract;
  logic                          last_op;
  logic signed [ACC_BITS-1:0]    acc_base, acc_next, acc_abs;
  logic signed [31:0]            one32, root32;
  logic signed [WEIGHT_BITS-1:0] area_w;
  logic signed [WEIGHT_BITS-1:0] q_w;

  always_comb begin
    px[0] = vx[0]; px[1] = vx[1]; px[2] = vx[2]; px[3] = qx;
    py[0] = vy[0]; py[1] = vy[1]; py[2] = vy[2]; py[3] = qy;
    a_i = 2'd0; b_i = 2'd1; c_i = 2'd2; sq = 1'b0; geo = 1'b1;
    unique case (phase)
      PH_EDGE_T: begin a_i = 2'd0; b_i = 2'd1; sq = 1'b1; end
      PH_EDGE_N: begin a_i = 2'd0; b_i = 2'd3; sq = 1'b1; end
      PH_TRI_T:  begin a_i = 2'd0; b_i = 2'd1; c_i = 2'd2; end
      PH_A0:     begin a_i = 2'd1; b_i = 2'd2; c_i = 2'd3; end
      PH_A1:     begin a_i = 2'd0; b_i = 2'd3; c_i = 2'd2; end
      PH_A2:     begin a_i = 2'd0; b_i = 2'd1; c_i = 2'd3; end
      PH_IX, PH_IY: begin geo = 1'b0; end
      default: ;
    endcase
    dbx = DIFF_BITS'(px[b_i]) - DIFF_BITS'(px[a_i]);
    dby = DIFF_BITS'(py[b_i]) - DIFF_BITS'(py[a_i]);
    dcx = DIFF_BITS'(px[c_i]) - DIFF_BITS'(px[a_i]);
    dcy = DIFF_BITS'(py[c_i]) - DIFF_BITS'(py[a_i]);
    if (op == 2'd0) begin
      f1 = dbx;
      f2 = sq ? dbx : dcy;
    end else begin
      f1 = sq ? dby : dcx;
      f2 = dby;
    end
    if (geo) begin
      ma = SCREEN_BITS'(f1);
      mb = WEIGHT_BITS'(f2);
    end else begin
      ma = (phase == PH_IX) ? sx[op] : sy[op];
      mb = w[op];
    end
    subtract = geo && !sq && (op == 2'd1);
    last_op  = geo ? (op == 2'd1) : (op == fcnt - 2'd1);
    acc_base = (op == 2'd0) ? '0 : acc;
    acc_next = subtract ? acc_base - ACC_BITS'(prod) : acc_base + ACC_BITS'(prod);
    acc_abs  = acc[ACC_BITS-1] ? -acc : acc;
    one32    = 32'sd1 <<< WEIGHT_FRAC_BITS;
    root32   = 32'(sqrt_rsp.root);
    q_w      = WEIGHT_BITS'(div_rsp.quot);
    if (div_neg) area_w = div_rsp.sat ? sat_weight(-32'sd1 <<< WEIGHT_BITS) : -q_w;
    else         area_w = div_rsp.sat ? sat_weight(32'sd1 <<< WEIGHT_BITS) : q_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      vcount         <= 3'd0;
      bad            <= 1'b0;
      m_tvalid       <= 1'b0;
      div_req.start  <= 1'b0;
      sqrt_req.start <= 1'b0;
    end else begin
      div_req.start  <= 1'b0;
      sqrt_req.start <= 1'b0;
      if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (vcount < 3'd3) begin
              vx[vcount[1:0]] <= in_loc_x;
              vy[vcount[1:0]] <= in_loc_y;
              sx[vcount[1:0]] <= in_sx;
              sy[vcount[1:0]] <= in_sy;
            end
            vcount <= cnt_new;
            bad    <= bad_new;
            if (s_tlast) begin
              vcount <= 3'd0;
              bad    <= 1'b0;
              qx     <= in_qx;
              qy     <= in_qy;
              fcnt   <= cnt_new[1:0];
              op     <= 2'd0;
              w[1]   <= '0;
              w[2]   <= '0;
              if (bad_new || cnt_new > 3'd3) begin
                w[0]  <= '0;
                ix    <= '0;
                iy    <= '0;
                ok_r  <= 1'b0;
                state <= ST_OUT;
              end else if (cnt_new == 3'd1) begin
                w[0]  <= sat_weight(one32);
                phase <= PH_IX;
                state <= ST_MUL;
              end else if (cnt_new == 3'd2) begin
                phase <= PH_EDGE_T;
                state <= ST_MUL;
              end else begin
                phase <= PH_TRI_T;
                state <= ST_MUL;
              end
            end
          end
        end
        ST_MUL: begin
          prod  <= ma * mb;
          state <= ST_ACC;
        end
        ST_ACC: begin
          acc <= acc_next;
          if (last_op) begin
            state <= ST_END;
          end else begin
            op    <= op + 2'd1;
            state <= ST_MUL;
          end
        end
        ST_END: begin
          op    <= 2'd0;
          state <= ST_MUL;
          unique case (phase)
            PH_EDGE_T: begin
              tval  <= MAG_BITS'(acc);
              phase <= PH_EDGE_N;
            end
            PH_EDGE_N: begin
              if (tval == '0) begin
                w[0] <= '0; w[1] <= '0; w[2] <= '0;
                ix <= '0; iy <= '0; ok_r <= 1'b0;
                state <= ST_OUT;
              end else begin
                div_req.start     <= 1'b1;
                div_req.edge_mode <= 1'b1;
                div_req.num       <= MAG_BITS'(acc);
                div_req.den       <= tval;
                state             <= ST_DIV;
              end
            end
            PH_TRI_T: begin
              if (acc == '0) begin
                w[0] <= '0; w[1] <= '0; w[2] <= '0;
                ix <= '0; iy <= '0; ok_r <= 1'b0;
                state <= ST_OUT;
              end else begin
                tot_neg <= acc[ACC_BITS-1];
                tot_mag <= MAG_BITS'(acc_abs);
                phase   <= PH_A0;
              end
            end
            PH_A0, PH_A1, PH_A2: begin
              div_req.start     <= 1'b1;
              div_req.edge_mode <= 1'b0;
              div_req.num       <= MAG_BITS'(acc_abs);
              div_req.den       <= tot_mag;
              div_neg           <= acc[ACC_BITS-1] ^ tot_neg;
              state             <= ST_DIV;
            end
            PH_IX: begin
              ix    <= sat_screen(acc);
              phase <= PH_IY;
            end
            PH_IY: begin
              iy    <= sat_screen(acc);
              ok_r  <= 1'b1;
              state <= ST_OUT;
            end
            default: ;
          endcase
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            priority case (phase)
              PH_EDGE_N: begin
                sqrt_req.start    <= 1'b1;
                sqrt_req.radicand <= div_rsp.quot;
                state             <= ST_SQRT;
              end
              PH_A0: begin w[0] <= area_w; phase <= PH_A1; state <= ST_MUL; end
              PH_A1: begin w[1] <= area_w; phase <= PH_A2; state <= ST_MUL; end
              default: begin w[2] <= area_w; phase <= PH_IX; state <= ST_MUL; end
            endcase
          end
        end
        ST_SQRT: begin
          if (sqrt_rsp.done) begin
            w[1]  <= sat_weight(root32);
            w[0]  <= sat_weight(one32 - root32);
            phase <= PH_IX;
            state <= ST_MUL;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {{M_PAD_BITS{1'b0}}, iy, ix, w[2], w[1], w[0]};
            m_tuser  <= ok_r;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  bci_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  bci_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (sqrt_req),
    .rsp (sqrt_rsp)
  );

endmodule
`default_nettype wire

[design/bci_checker.sv]
// Port-level checker for the barycentric interpolator, bound to the top level.
`default_nettype none
module bci_checker import bci_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    s_tvalid,
  input logic                    s_tready,
  input logic                    s_tlast,
  input logic                    m_tvalid,
  input logic                    m_tready,
  input logic [M_TDATA_BITS-1:0] m_tdata,
  input logic                    m_tuser
);

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // A failure result carries all-zero data.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("failure result with nonzero data");

  // The closing vertex starts a computation, so input stalls next.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input ready right after closing vertex");

  // A new result is only loaded while input is stalled.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared while input was ready");

  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind barycentric_interpolator_top bci_checker u_bci_checker (.*);
`default_nettype wire
